/* rtl/fltw_pkg.sv */
package fltw_pkg;

  localparam int VA_W    = 48;
  localparam int FRAME_W = 40;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;
  localparam int CFG_W   = 40;
  localparam int ROOT_W  = 6;
  localparam int FTF_W   = 7;

  localparam logic [1:0] ACT_CHECK   = 2'd0;
  localparam logic [1:0] ACT_MAP     = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_EXHAUSTED = 2'd1;
  localparam logic [1:0] ERR_RANGE     = 2'd2;

  localparam logic [1:0] REG_ROOT_FRAME        = 2'd0;
  localparam logic [1:0] REG_FIRST_TABLE_FRAME = 2'd1;
  localparam logic [1:0] REG_FIRST_USER_FRAME  = 2'd2;

  localparam logic [ROOT_W-1:0]  RST_ROOT_FRAME        = 6'd0;
  localparam logic [FTF_W-1:0]   RST_FIRST_TABLE_FRAME = 7'd1;
  localparam logic [FRAME_W-1:0] RST_FIRST_USER_FRAME  = 40'd4096;

  localparam int BIT_P = 0;
  localparam int BIT_W = 1;
  localparam int BIT_U = 2;
  localparam logic [11:0] NEW_ENTRY_BITS = 12'h005;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_READ,
    UOP_EVAL,
    UOP_WRITE,
    UOP_EMIT,
    UOP_CLEAR
  } uop_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_HALT,
    COND_MORE,
    COND_OUT_FREE,
    COND_CLR_DONE
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_READ  = 3'd1;
  localparam step_t STEP_EVAL  = 3'd2;
  localparam step_t STEP_WRITE = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;
  localparam step_t STEP_CLEAR = 3'd5;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t t_step;
    step_t f_step;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic halt;
    logic more;
    logic out_free;
    logic clr_done;
  } flags_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t cw;
    case (step)
      STEP_IDLE:  cw = '{UOP_LOAD,  COND_ACCEPT,   STEP_READ,  STEP_IDLE};
      STEP_READ:  cw = '{UOP_READ,  COND_HALT,     STEP_EMIT,  STEP_EVAL};
      STEP_EVAL:  cw = '{UOP_EVAL,  COND_HALT,     STEP_EMIT,  STEP_WRITE};
      STEP_WRITE: cw = '{UOP_WRITE, COND_MORE,     STEP_READ,  STEP_EMIT};
      STEP_EMIT:  cw = '{UOP_EMIT,  COND_OUT_FREE, STEP_IDLE,  STEP_EMIT};
      STEP_CLEAR: cw = '{UOP_CLEAR, COND_CLR_DONE, STEP_IDLE,  STEP_CLEAR};
      default:    cw = '{UOP_NOP,   COND_ALWAYS,   STEP_IDLE,  STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

/* rtl/fltw_store.sv */
module fltw_store #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/fltw_seq.sv */
module fltw_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  fltw_pkg::flags_t flags,
  output fltw_pkg::ctrl_t  ctrl
);

  import fltw_pkg::*;

  step_t step_r;
  step_t step_nxt;
  ctrl_t cw;
  logic  take;

  assign cw = ucode_rom(step_r);

  always_comb begin
    case (cw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_ACCEPT:   take = flags.accept;
      COND_HALT:     take = flags.halt;
      COND_MORE:     take = flags.more;
      COND_OUT_FREE: take = flags.out_free;
      COND_CLR_DONE: take = flags.clr_done;
      default:       take = 1'b1;
    endcase
    step_nxt = take ? cw.t_step : cw.f_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl = cw;

endmodule

/* rtl/fltw_dp.sv */
module fltw_dp #(
  parameter int TABLE_FRAMES = 64,
  parameter int AW           = 15,
  parameter int FW           = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fltw_pkg::ctrl_t                 ctrl,
  output fltw_pkg::flags_t                flags,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [fltw_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [fltw_pkg::VA_W-1:0]       in_virt_addr,
  input  logic                            in_writable,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic [fltw_pkg::FRAME_W-1:0]    out_freed_frame,
  output logic [fltw_pkg::ENTRY_W-1:0]    out_leaf_entry,
  output logic [1:0]                      out_error,
  output logic                            mem_re,
  output logic [AW-1:0]                   mem_raddr,
  input  logic [fltw_pkg::ENTRY_W-1:0]    mem_rdata,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output logic [fltw_pkg::ENTRY_W-1:0]    mem_wdata
);

  import fltw_pkg::*;

  localparam int DEPTH = TABLE_FRAMES * 512;
  localparam int TCW   = ($clog2(TABLE_FRAMES + 1) > FTF_W) ? $clog2(TABLE_FRAMES + 1) : FTF_W;

  logic [1:0]         act_r, act_nxt;
  logic [VA_W-1:0]    va_r, va_nxt;
  logic               wr_r, wr_nxt;
  logic [1:0]         level_r, level_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [ENTRY_W-1:0] ent_r, ent_nxt;
  logic               wpend_r, wpend_nxt;
  logic               ok_r, ok_nxt;
  logic [FRAME_W-1:0] freed_r, freed_nxt;
  logic [ENTRY_W-1:0] leaf_r, leaf_nxt;
  logic [1:0]         err_r, err_nxt;

  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [TCW-1:0]     next_tf_r, next_tf_nxt;
  logic [FRAME_W-1:0] next_uf_r, next_uf_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r;
  logic [FRAME_W-1:0] out_freed_r;
  logic [ENTRY_W-1:0] out_leaf_r;
  logic [1:0]         out_err_r;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      slot;
  logic               oos;
  logic               accept;
  logic               out_free;
  logic               halt;
  logic               p_bit;
  logic               pu_bit;
  logic [FRAME_W-1:0] nf;
  logic [ENTRY_W-1:0] e_new;
  logic               tf_full;

  always_comb begin
    case (level_r)
      2'd3:    idx = va_r[47:39];
      2'd2:    idx = va_r[38:30];
      2'd1:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign slot     = {frame_r[FW-1:0], idx};
  assign oos      = frame_r >= FRAME_W'(TABLE_FRAMES);
  assign accept   = (ctrl.uop == UOP_LOAD) && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign p_bit    = mem_rdata[BIT_P];
  assign pu_bit   = mem_rdata[BIT_P] & mem_rdata[BIT_U];
  assign tf_full  = next_tf_r >= TCW'(TABLE_FRAMES);

  always_comb begin
    act_nxt      = act_r;
    va_nxt       = va_r;
    wr_nxt       = wr_r;
    level_nxt    = level_r;
    frame_nxt    = frame_r;
    ent_nxt      = ent_r;
    wpend_nxt    = wpend_r;
    ok_nxt       = ok_r;
    freed_nxt    = freed_r;
    leaf_nxt     = leaf_r;
    err_nxt      = err_r;
    root_nxt     = root_r;
    next_tf_nxt  = next_tf_r;
    next_uf_nxt  = next_uf_r;
    clr_addr_nxt = clr_addr_r;
    halt         = 1'b0;
    nf           = '0;
    e_new        = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = slot;
    mem_we       = 1'b0;
    mem_waddr    = slot;
    mem_wdata    = ent_r;

    case (ctrl.uop)
      UOP_LOAD: begin
        if (accept) begin
          act_nxt   = in_action;
          va_nxt    = in_virt_addr;
          wr_nxt    = in_writable;
          level_nxt = 2'd3;
          frame_nxt = FRAME_W'(root_r);
          ok_nxt    = 1'b0;
          freed_nxt = '0;
          leaf_nxt  = '0;
          err_nxt   = ERR_NONE;
        end
      end
      UOP_READ: begin
        if (act_r == ACT_NONE) begin
          halt = 1'b1;
        end else if (oos) begin
          halt    = 1'b1;
          err_nxt = ERR_RANGE;
        end else begin
          mem_re = 1'b1;
        end
      end
      UOP_EVAL: begin
        wpend_nxt = 1'b0;
        ent_nxt   = mem_rdata;
        case (act_r)
          ACT_CHECK: begin
            if (!pu_bit) begin
              halt = 1'b1;
            end else if (level_r == 2'd0) begin
              halt     = 1'b1;
              ok_nxt   = 1'b1;
              leaf_nxt = mem_rdata;
            end
          end
          ACT_MAP: begin
            if (!p_bit) begin
              if (level_r == 2'd0) begin
                nf          = next_uf_r;
                next_uf_nxt = next_uf_r + 1'b1;
              end else if (tf_full) begin
                halt    = 1'b1;
                err_nxt = ERR_EXHAUSTED;
              end else begin
                nf          = FRAME_W'(next_tf_r);
                next_tf_nxt = next_tf_r + 1'b1;
              end
              e_new = {12'd0, nf, NEW_ENTRY_BITS};
            end
            e_new[BIT_W] = wr_r;
            if (!halt) begin
              ent_nxt   = e_new;
              wpend_nxt = 1'b1;
              if (level_r == 2'd0) begin
                ok_nxt   = 1'b1;
                leaf_nxt = e_new;
              end
            end
          end
          ACT_RELEASE: begin
            if (level_r == 2'd0) begin
              if (pu_bit) begin
                freed_nxt = mem_rdata[51:12];
                ent_nxt   = '0;
                wpend_nxt = 1'b1;
                ok_nxt    = 1'b1;
                leaf_nxt  = '0;
              end else begin
                halt     = 1'b1;
                leaf_nxt = mem_rdata;
              end
            end else if (!p_bit) begin
              halt = 1'b1;
            end
          end
          default: begin
            halt = 1'b1;
          end
        endcase
      end
      UOP_WRITE: begin
        mem_we    = wpend_r;
        frame_nxt = ent_r[51:12];
        level_nxt = level_r - 2'd1;
      end
      UOP_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_ROOT_FRAME:        root_nxt    = cfg_data[ROOT_W-1:0];
        REG_FIRST_TABLE_FRAME: next_tf_nxt = TCW'(cfg_data[FTF_W-1:0]);
        REG_FIRST_USER_FRAME:  next_uf_nxt = cfg_data[FRAME_W-1:0];
        default: begin
        end
      endcase
    end

    if ((ctrl.uop == UOP_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= RST_ROOT_FRAME;
      next_tf_r   <= TCW'(RST_FIRST_TABLE_FRAME);
      next_uf_r   <= RST_FIRST_USER_FRAME;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      wpend_r     <= 1'b0;
      act_r       <= ACT_NONE;
    end else begin
      root_r      <= root_nxt;
      next_tf_r   <= next_tf_nxt;
      next_uf_r   <= next_uf_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      wpend_r     <= wpend_nxt;
      act_r       <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r    <= va_nxt;
    wr_r    <= wr_nxt;
    level_r <= level_nxt;
    frame_r <= frame_nxt;
    ent_r   <= ent_nxt;
    ok_r    <= ok_nxt;
    freed_r <= freed_nxt;
    leaf_r  <= leaf_nxt;
    err_r   <= err_nxt;
    if ((ctrl.uop == UOP_EMIT) && out_free) begin
      out_ok_r    <= ok_r;
      out_freed_r <= freed_r;
      out_leaf_r  <= leaf_r;
      out_err_r   <= err_r;
    end
  end

  assign flags.accept   = accept;
  assign flags.halt     = halt;
  assign flags.more     = level_r != 2'd0;
  assign flags.out_free = out_free;
  assign flags.clr_done = clr_addr_r == AW'(DEPTH - 1);

  assign in_stall        = ctrl.uop != UOP_LOAD;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_freed_frame = out_freed_r;
  assign out_leaf_entry  = out_leaf_r;
  assign out_error       = out_err_r;

endmodule

/* rtl/four_level_page_table_walker.sv */
// Four-level page table walker over an on-chip table store.
// Input word: in_action, in_virt_addr, in_writable, taken when in_valid is
// high and in_stall low. Result word: out_ok, out_freed_frame,
// out_leaf_entry, out_error, taken when out_valid is high and out_stall low.
// cfg_we writes register cfg_index (0 root frame, 1 first table frame,
// 2 first user frame) with cfg_data; write only while the walker is idle.
// A microcode sequencer runs each word: a load step, then per level a store
// read, an evaluate step and, when the walk goes on or the entry changes, a
// write-back step, then an emit step that waits until the output register is
// free. Each level's read needs the entry read one level up, and the store
// returns data the cycle after the read. One word is in flight at a time; the
// result is valid the cycle after the emit cycle.
// After reset the store is cleared one entry per cycle, all TABLE_FRAMES * 512
// entries (32768 by default); in_stall stays high until then, while register
// writes are taken. A stalled result holds in the output register; the next
// word is loaded while it waits and emitted once the register frees.
module four_level_page_table_walker #(
  parameter int TABLE_FRAMES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [fltw_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [fltw_pkg::VA_W-1:0]    in_virt_addr,
  input  logic                         in_writable,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_ok,
  output logic [fltw_pkg::FRAME_W-1:0] out_freed_frame,
  output logic [fltw_pkg::ENTRY_W-1:0] out_leaf_entry,
  output logic [1:0]                   out_error
);

  import fltw_pkg::*;

  localparam int FW    = $clog2(TABLE_FRAMES);
  localparam int AW    = FW + IDX_W;
  localparam int DEPTH = TABLE_FRAMES * 512;

  ctrl_t              ctrl;
  flags_t             flags;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  fltw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  fltw_dp #(
    .TABLE_FRAMES (TABLE_FRAMES),
    .AW           (AW),
    .FW           (FW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .flags           (flags),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_virt_addr    (in_virt_addr),
    .in_writable     (in_writable),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_freed_frame (out_freed_frame),
    .out_leaf_entry  (out_leaf_entry),
    .out_error       (out_error),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata)
  );

  fltw_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ENTRY_W)
  ) u_store (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

endmodule

/* rtl/fltw_checker.sv */
module fltw_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_ok,
  input logic [fltw_pkg::FRAME_W-1:0] out_freed_frame,
  input logic [fltw_pkg::ENTRY_W-1:0] out_leaf_entry,
  input logic [1:0]                   out_error
);

  import fltw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_freed_frame)
      && $stable(out_leaf_entry) && $stable(out_error))
    else $error("result word changed while stalled");

  a_err_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != ERR_NONE) |-> !out_ok)
    else $error("error reported with ok set");

  a_freed_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_freed_frame != '0) |-> out_ok && (out_leaf_entry == '0)
      && (out_error == ERR_NONE))
    else $error("freed frame without a cleared leaf");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error == ERR_NONE) || (out_error == ERR_EXHAUSTED)
      || (out_error == ERR_RANGE))
    else $error("undefined error code");

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_ok          (out_ok),
  .out_freed_frame (out_freed_frame),
  .out_leaf_entry  (out_leaf_entry),
  .out_error       (out_error)
);

/* test/four_level_page_table_walker_tb.sv */
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;
  import fltw_pkg::*;

  localparam int TABLE_FRAMES    = 64;
  localparam int TABLE_WORDS     = TABLE_FRAMES * 512;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int WORDS_PER_PHASE = 150;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] freed_frame;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [1:0]         error;
  } walk_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_ROOT_FRAME;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_CHECK;
  logic [VA_W-1:0]    in_virt_addr = '0;
  logic               in_writable = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_ok;
  logic [FRAME_W-1:0] out_freed_frame;
  logic [ENTRY_W-1:0] out_leaf_entry;
  logic [1:0]         out_error;

  logic [ENTRY_W-1:0] shadow_tables [TABLE_WORDS];
  logic [ROOT_W-1:0]  root_frame_q;
  logic [FTF_W-1:0]   next_table_frame_q;
  logic [FRAME_W-1:0] next_user_frame_q;
  logic [8:0]         level_idx [4][4];

  walk_result_t pending_results[$];

  int  cycles;
  int  mismatches;
  int  reg_writes;
  int  maps_sent, checks_sent, releases_sent, unused_sent;
  int  ok_seen, exhausted_seen, range_seen;
  int  rx_hold;
  int  rx_burst;
  logic src_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;

  four_level_page_table_walker #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_virt_addr   (in_virt_addr),
    .in_writable    (in_writable),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_freed_frame(out_freed_frame),
    .out_leaf_entry (out_leaf_entry),
    .out_error      (out_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Walk the shadow tables the way the block does and update them.
  function automatic walk_result_t walk_tables(input logic [1:0] act,
                                               input logic [VA_W-1:0] va,
                                               input logic wr);
    walk_result_t       r;
    logic [FRAME_W-1:0] frame;
    logic [ENTRY_W-1:0] e;
    logic [8:0]         idx;
    logic               stop;
    int                 lvl;
    int                 slot;
    r = '0;
    frame = FRAME_W'(root_frame_q);
    stop = 1'b0;
    if (act != ACT_NONE) begin
      for (lvl = 3; lvl >= 0; lvl--) begin
        if (!stop) begin
          if (frame >= TABLE_FRAMES) begin
            r.error = ERR_RANGE;
            stop = 1'b1;
          end else begin
            idx = va[12 + 9 * lvl +: 9];
            slot = int'(frame[5:0]) * 512 + int'(idx);
            e = shadow_tables[slot];
            case (act)
              ACT_CHECK: begin
                if (!e[BIT_P] || !e[BIT_U]) begin
                  stop = 1'b1;
                end else if (lvl == 0) begin
                  r.ok = 1'b1;
                  r.leaf_entry = e;
                end
              end
              ACT_MAP: begin
                if (!e[BIT_P]) begin
                  if (lvl == 0) begin
                    e = {12'd0, next_user_frame_q, NEW_ENTRY_BITS};
                    next_user_frame_q = next_user_frame_q + 1'b1;
                  end else if (next_table_frame_q >= TABLE_FRAMES) begin
                    r.error = ERR_EXHAUSTED;
                    stop = 1'b1;
                  end else begin
                    e = {12'd0, 33'd0, next_table_frame_q, NEW_ENTRY_BITS};
                    next_table_frame_q = next_table_frame_q + 1'b1;
                  end
                end
                if (!stop) begin
                  e[BIT_W] = wr;
                  shadow_tables[slot] = e;
                  if (lvl == 0) begin
                    r.ok = 1'b1;
                    r.leaf_entry = e;
                  end
                end
              end
              default: begin
                if (lvl == 0) begin
                  if (e[BIT_P] && e[BIT_U]) begin
                    r.freed_frame = e[51:12];
                    shadow_tables[slot] = '0;
                    r.ok = 1'b1;
                  end else begin
                    r.leaf_entry = e;
                  end
                end else if (!e[BIT_P]) begin
                  stop = 1'b1;
                end
              end
            endcase
            if (!stop) frame = e[51:12];
          end
        end
      end
    end
    return r;
  endfunction

  // Receiver: random stall bursts, plus a long hold on request.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else if (rx_burst > 0) begin
      out_stall <= 1'b1;
      rx_burst = rx_burst - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_burst = $urandom_range(1, 9) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at cycle %0d: expected %h, got %h", name, cycles,
                 want, got);
    end
  endfunction

  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        compare_field("ok", 64'(want.ok), 64'(out_ok));
        compare_field("freed_frame", 64'(want.freed_frame), 64'(out_freed_frame));
        compare_field("leaf_entry", want.leaf_entry, out_leaf_entry);
        compare_field("error", 64'(want.error), 64'(out_error));
        if (want.ok) ok_seen++;
        if (want.error == ERR_EXHAUSTED) exhausted_seen++;
        if (want.error == ERR_RANGE) range_seen++;
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [VA_W-1:0] va,
                           input logic wr);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_action    <= act;
    in_virt_addr <= va;
    in_writable  <= wr;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(walk_tables(act, va, wr));
    case (act)
      ACT_CHECK:   checks_sent++;
      ACT_MAP:     maps_sent++;
      ACT_RELEASE: releases_sent++;
      default:     unused_sent++;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    case (index)
      REG_ROOT_FRAME:        root_frame_q = value[ROOT_W-1:0];
      REG_FIRST_TABLE_FRAME: next_table_frame_q = value[FTF_W-1:0];
      REG_FIRST_USER_FRAME:  next_user_frame_q = value[FRAME_W-1:0];
      default:               ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_address_pool();
    for (int l = 0; l < 4; l++) begin
      level_idx[l][0] = 9'd0;
      level_idx[l][1] = 9'd511;
      level_idx[l][2] = 9'($urandom_range(0, 511));
      level_idx[l][3] = 9'($urandom_range(0, 511));
    end
  endtask

  function automatic logic [VA_W-1:0] pool_address();
    logic [VA_W-1:0] va;
    va[11:0] = 12'($urandom_range(0, 4095));
    for (int l = 0; l < 4; l++) va[12 + 9 * l +: 9] = level_idx[l][$urandom_range(0, 3)];
    return va;
  endfunction

  task automatic test_empty_store();
    send_word(ACT_CHECK, '0, 1'b0);
    send_word(ACT_RELEASE, '0, 1'b0);
    send_word(ACT_NONE, '1, 1'b1);
  endtask

  task automatic test_map_and_release();
    send_word(ACT_MAP, '0, 1'b1);
    send_word(ACT_CHECK, '0, 1'b0);
    send_word(ACT_MAP, '1, 1'b0);
    send_word(ACT_CHECK, '1, 1'b1);
    send_word(ACT_MAP, '0, 1'b0);
    send_word(ACT_RELEASE, '1, 1'b0);
    send_word(ACT_RELEASE, '1, 1'b1);
    send_word(ACT_CHECK, '1, 1'b0);
  endtask

  // Root on the leaf table of address zero: the next frame is a data page.
  task automatic test_out_of_store();
    drain_results();
    write_reg(REG_ROOT_FRAME, 64'd3);
    send_word(ACT_CHECK, '0, 1'b0);
    send_word(ACT_MAP, '0, 1'b1);
    send_word(ACT_RELEASE, '0, 1'b0);
  endtask

  task automatic test_exhaustion();
    drain_results();
    write_reg(REG_ROOT_FRAME, 64'd0);
    write_reg(REG_FIRST_TABLE_FRAME, 64'd63);
    send_word(ACT_MAP, 48'h0280_0000_0000, 1'b1);
    drain_results();
    write_reg(REG_FIRST_TABLE_FRAME, 64'd64);
    send_word(ACT_MAP, 48'h0300_0000_0000, 1'b0);
  endtask

  task automatic test_backpressure();
    drain_results();
    write_reg(REG_FIRST_TABLE_FRAME, 64'd8);
    build_address_pool();
    src_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    @(posedge clk);
    rx_hold = 300;
    repeat (8) send_word($urandom_range(0, 1) ? ACT_MAP : ACT_CHECK, pool_address(),
                         1'($urandom_range(0, 1)));
    drain_results();
    src_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_phase(input logic [63:0] root, input logic [63:0] first_table,
                                   input logic [63:0] first_user, input logic quiet);
    int              pick;
    logic [63:0]     wide;
    logic [VA_W-1:0] va;
    drain_results();
    write_reg(REG_ROOT_FRAME, root);
    write_reg(REG_FIRST_TABLE_FRAME, first_table);
    write_reg(REG_FIRST_USER_FRAME, first_user);
    build_address_pool();
    for (int n = 0; n < WORDS_PER_PHASE; n++) begin
      src_idle_en = !quiet && (n % 50) < 38;
      rx_idle_en = !quiet && (n % 50) < 38;
      pick = $urandom_range(0, 99);
      va = pool_address();
      if (pick < 40) begin
        send_word(ACT_MAP, va, 1'($urandom_range(0, 1)));
      end else if (pick < 68) begin
        send_word(ACT_CHECK, va, 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        send_word(ACT_RELEASE, va, 1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
        send_word(ACT_NONE, va, 1'($urandom_range(0, 1)));
      end else begin
        wide = {$urandom(), $urandom()};
        send_word(2'($urandom_range(0, 3)), wide[VA_W-1:0], 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic [63:0] wide;
    for (int i = 0; i < TABLE_WORDS; i++) shadow_tables[i] = '0;
    root_frame_q = RST_ROOT_FRAME;
    next_table_frame_q = RST_FIRST_TABLE_FRAME;
    next_user_frame_q = RST_FIRST_USER_FRAME;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_map_and_release();
    test_out_of_store();
    test_exhaustion();
    test_backpressure();

    wide = {$urandom(), $urandom()};
    test_random_phase(64'd0, 64'd7, {24'd0, wide[39:0]}, 1'b0);
    test_random_phase(64'd63, 64'd20, 64'hFF_FFFF_FFFF, 1'b0);
    test_random_phase(64'($urandom_range(0, 63)), 64'd0, 64'd0, 1'b0);
    test_random_phase(64'd17, 64'd40, 64'd10, 1'b0);
    test_random_phase(64'd0, 64'd64, 64'd4096, 1'b0);
    wide = {$urandom(), $urandom()};
    test_random_phase(64'($urandom_range(0, 63)), 64'd30, {24'd0, wide[39:0]}, 1'b1);

    drain_results();
    repeat (30) @(posedge clk);
    $display("walked %0d map, %0d check, %0d release and %0d unused words; %0d register writes",
             maps_sent, checks_sent, releases_sent, unused_sent, reg_writes);
    $display("outcomes: %0d ok, %0d exhausted, %0d out of store; %0d mismatches",
             ok_seen, exhausted_seen, range_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
